// ----- rtl/biquad_iir_audio_filter_assert.svh -----
// ----------------------------------------------------------------------------
// Biquad filter assertion macros
// Concurrent assertion wrappers that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_AUDIO_FILTER_ASSERT_SVH
`define BIQUAD_IIR_AUDIO_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define BQ_ASSERT_NOW(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define BQ_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define BQ_ASSERT_NOW(lbl, expr)
`define BQ_ASSERT_NEXT(lbl, cond, expr)
`endif
`endif

// ----- rtl/bq_pkg.sv -----
// ----------------------------------------------------------------------------
// Biquad filter package
// Register map, fixed-point widths and shared constants.
// ----------------------------------------------------------------------------
package bq_pkg;

  localparam int COEF_FRAC_BITS = 13;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 16;
  localparam int HIST_W         = 32;
  localparam int FF_PROD_W      = COEF_W + SAMPLE_W;
  localparam int FF_SUM_W       = FF_PROD_W + 2;
  localparam int FB_PROD_W      = COEF_W + HIST_W;
  localparam int ACC_W          = FB_PROD_W + 3;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;

  localparam logic [ACC_W-1:0] FRAC_MASK = ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);

  typedef enum logic [2:0] {
    REG_SIGN_MODE   = 3'd0,
    REG_COEF_FEED_0 = 3'd1,
    REG_COEF_FEED_1 = 3'd2,
    REG_COEF_FEED_2 = 3'd3,
    REG_COEF_BACK_1 = 3'd4,
    REG_COEF_BACK_2 = 3'd5
  } reg_idx_t;

  localparam logic signed [COEF_W-1:0] COEF_FEED_0_RST = 16'sd8192;

endpackage

// ----- rtl/biquad_iir_audio_filter.sv -----
// ----------------------------------------------------------------------------
// Biquad IIR audio filter
// Second-order direct-form-1 filter on 16-bit samples with Q13 coefficients.
// ----------------------------------------------------------------------------
// The filter accepts one sample per clock unless out_ready stalls the output;
// each result passes the stage-one register, then the output register. Stage
// one registers the feedforward sum of three 16x16 products; stage two
// subtracts the two 16x32 feedback products against the stored output history,
// truncates toward zero and clamps into the output register. That feedback
// multiply-add in stage two is the recurrence that sets the one-sample-per-cycle
// rate. Coefficients may only be written while no beat is in flight.
`include "biquad_iir_audio_filter_assert.svh"

module biquad_iir_audio_filter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [15:0]                in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [15:0]                out_sample_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bq_pkg::ADDR_W-1:0]  paddr,
  input  logic [bq_pkg::DATA_W-1:0]  pwdata,
  output logic [bq_pkg::DATA_W-1:0]  prdata,
  output logic                       pready
);
  import bq_pkg::*;

  logic                       sign_mode_r;
  logic signed [COEF_W-1:0]   coef_feed_0_r, coef_feed_1_r, coef_feed_2_r;
  logic signed [COEF_W-1:0]   coef_back_1_r, coef_back_2_r;
  logic signed [SAMPLE_W-1:0] in_hist_1_r, in_hist_2_r;
  logic signed [HIST_W-1:0]   out_hist_1_r, out_hist_2_r;
  logic                       s1_valid_r;
  logic signed [FF_SUM_W-1:0] ff_r, ff_nxt;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_sample_r, out_sample_nxt;

  logic                       cfg_wr;
  reg_idx_t                   reg_idx;
  logic                       in_fire, out_free, adv;
  logic signed [SAMPLE_W-1:0] x0;
  logic signed [FF_PROD_W-1:0] p0, p1, p2;
  logic signed [FB_PROD_W-1:0] m1, m2;
  logic signed [ACC_W-1:0]    acc, acc_adj, qw;
  logic signed [HIST_W-1:0]   y0;
  logic                       q_fits, y_fits;
  logic [SAMPLE_W-1:0]        v16;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_mode_r   <= 1'b0;
      coef_feed_0_r <= COEF_FEED_0_RST;
      coef_feed_1_r <= '0;
      coef_feed_2_r <= '0;
      coef_back_1_r <= '0;
      coef_back_2_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SIGN_MODE:   sign_mode_r   <= pwdata[0];
        REG_COEF_FEED_0: coef_feed_0_r <= pwdata[COEF_W-1:0];
        REG_COEF_FEED_1: coef_feed_1_r <= pwdata[COEF_W-1:0];
        REG_COEF_FEED_2: coef_feed_2_r <= pwdata[COEF_W-1:0];
        REG_COEF_BACK_1: coef_back_1_r <= pwdata[COEF_W-1:0];
        REG_COEF_BACK_2: coef_back_2_r <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIGN_MODE:   prdata = DATA_W'(sign_mode_r);
      REG_COEF_FEED_0: prdata = DATA_W'(coef_feed_0_r);
      REG_COEF_FEED_1: prdata = DATA_W'(coef_feed_1_r);
      REG_COEF_FEED_2: prdata = DATA_W'(coef_feed_2_r);
      REG_COEF_BACK_1: prdata = DATA_W'(coef_back_1_r);
      REG_COEF_BACK_2: prdata = DATA_W'(coef_back_2_r);
      default:         prdata = '0;
    endcase
  end

  // Handshake.
  assign out_free = !out_valid_r || out_ready;
  assign adv      = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  // Stage one: center the sample and form the feedforward sum.
  assign x0 = signed'(in_sample_in ^ {~sign_mode_r, {(SAMPLE_W-1){1'b0}}});
  assign p0 = FF_PROD_W'(coef_feed_0_r) * FF_PROD_W'(x0);
  assign p1 = FF_PROD_W'(coef_feed_1_r) * FF_PROD_W'(in_hist_1_r);
  assign p2 = FF_PROD_W'(coef_feed_2_r) * FF_PROD_W'(in_hist_2_r);
  assign ff_nxt = FF_SUM_W'(p0) + FF_SUM_W'(p1) + FF_SUM_W'(p2);

  // Stage two: feedback, truncating shift, saturation and clamp.
  assign m1  = FB_PROD_W'(coef_back_1_r) * FB_PROD_W'(out_hist_1_r);
  assign m2  = FB_PROD_W'(coef_back_2_r) * FB_PROD_W'(out_hist_2_r);
  assign acc = ACC_W'(ff_r) - ACC_W'(m1) - ACC_W'(m2);
  assign acc_adj = acc + (acc[ACC_W-1] ? signed'(FRAC_MASK) : '0);
  assign qw  = acc_adj >>> COEF_FRAC_BITS;

  assign q_fits = (qw[ACC_W-1:HIST_W-1] == '0) || (qw[ACC_W-1:HIST_W-1] == '1);
  assign y0 = q_fits ? qw[HIST_W-1:0]
                     : (qw[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}}
                                    : {1'b0, {(HIST_W-1){1'b1}}});

  assign y_fits = (y0[HIST_W-1:SAMPLE_W-1] == '0) || (y0[HIST_W-1:SAMPLE_W-1] == '1);
  assign v16 = y_fits ? {~y0[SAMPLE_W-1], y0[SAMPLE_W-2:0]}
                      : (y0[HIST_W-1] ? '0 : '1);
  assign out_sample_nxt = v16 ^ {sign_mode_r, {(SAMPLE_W-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      in_hist_1_r  <= '0;
      in_hist_2_r  <= '0;
      out_hist_1_r <= '0;
      out_hist_2_r <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r  <= 1'b1;
        in_hist_1_r <= x0;
        in_hist_2_r <= in_hist_1_r;
      end else if (adv) begin
        s1_valid_r  <= 1'b0;
      end
      if (adv) begin
        out_valid_r  <= 1'b1;
        out_hist_1_r <= y0;
        out_hist_2_r <= out_hist_1_r;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ff_r <= ff_nxt;
    end
    if (adv) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  `BQ_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_r)
  `BQ_ASSERT_NOW(a_no_overrun, !(in_fire && s1_valid_r && !out_free))
  `BQ_ASSERT_NEXT(a_hist_shift, adv, out_hist_2_r == $past(out_hist_1_r))
  `BQ_ASSERT_NOW(a_stall_only_full, in_ready || (s1_valid_r && out_valid_r && !out_ready))

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Biquad IIR audio filter testbench
// Drives samples through the filter under random sender bursts and receiver
// stalls, including one long receiver hold-off, and writes the coefficient
// and sign mode registers between phases. Each output beat is compared with
// a typed row's want or a cycle-free fixed-point model of the direct-form-1
// recurrence kept here. Directed rows come first, then random phases.
// ----------------------------------------------------------------------------
module tb;
  import bq_pkg::*;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;
  typedef enum int {STYLE_MAX, STYLE_MIN, STYLE_WILD, STYLE_STABLE} coef_style_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [31:0] data;
    logic        typed;
    logic [15:0] want;
  } row_t;

  localparam logic [2:0] REG_PAST_END_LO = 3'd6;
  localparam logic [2:0] REG_PAST_END_HI = 3'd7;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 10;
  localparam int IDLE_CYCLES     = 4;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DIRECTED_ROWS   = 31;

  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_SAMPLE, 3'd0, 32'h0000_0000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_ffff, 1'b1, 16'hffff},
    '{ROW_SAMPLE, 3'd0, 32'h0000_8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_1234, 1'b1, 16'h1234},
    '{ROW_WRITE, REG_SIGN_MODE, 32'hffff_ffff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_7fff, 1'b1, 16'h7fff},
    '{ROW_SAMPLE, 3'd0, 32'h0000_0000, 1'b1, 16'h0000},
    '{ROW_WRITE, REG_PAST_END_LO, 32'h0000_0001, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_PAST_END_HI, 32'hffff_ffff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_ffff, 1'b1, 16'hffff},
    '{ROW_WRITE, REG_COEF_FEED_0, 32'habcd_8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_4000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_c000, 1'b1, 16'h7fff},
    '{ROW_WRITE, REG_COEF_FEED_1, 32'h0000_7fff, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_COEF_FEED_2, 32'h1234_8000, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_COEF_BACK_1, 32'hffff_7fff, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_COEF_BACK_2, 32'hffff_8000, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_SIGN_MODE, 32'hffff_fffe, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_ffff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_ffff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_ffff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_5555, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_aaaa, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_ffff, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 3'd0, 32'h0000_ffff, 1'b0, 16'h0000}
  };

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [15:0]         in_sample_in   = 16'h0000;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [15:0]         out_sample_out;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [ADDR_W-1:0]   paddr          = '0;
  logic [DATA_W-1:0]   pwdata         = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic               mode_signed = 1'b0;
  logic signed [15:0] feed_coef [3] = '{COEF_FEED_0_RST, 16'sd0, 16'sd0};
  logic signed [15:0] back_coef [2] = '{16'sd0, 16'sd0};
  logic signed [15:0] x_past [2]    = '{16'sd0, 16'sd0};
  logic signed [31:0] y_past [2]    = '{32'sd0, 32'sd0};

  logic [15:0] awaited_out [$];
  int          errors      = 0;
  int unsigned cycle_count = 0;
  int          burst_left  = 0;
  bit          hold_req    = 1'b0;

  biquad_iir_audio_filter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] biquad_output(input logic [15:0] raw);
    logic [15:0]        flip;
    logic signed [15:0] xc;
    longint             acc;
    longint             y0;
    longint             v;
    flip = mode_signed ? 16'h8000 : 16'h0000;
    xc   = raw ^ flip ^ 16'h8000;
    acc  = longint'(feed_coef[0]) * longint'(xc)
         + longint'(feed_coef[1]) * longint'(x_past[0])
         + longint'(feed_coef[2]) * longint'(x_past[1])
         - longint'(back_coef[0]) * longint'(y_past[0])
         - longint'(back_coef[1]) * longint'(y_past[1]);
    y0 = acc / (longint'(1) << COEF_FRAC_BITS);
    if (y0 > longint'(32'sh7fff_ffff)) begin
      y0 = longint'(32'sh7fff_ffff);
    end else if (y0 < -longint'(33'sh0_8000_0000)) begin
      y0 = -longint'(33'sh0_8000_0000);
    end
    x_past[1] = x_past[0];
    x_past[0] = xc;
    y_past[1] = y_past[0];
    y_past[0] = 32'(y0);
    v = y0 + 32768;
    if (v < 0) begin
      v = 0;
    end else if (v > 65535) begin
      v = 65535;
    end
    return 16'(v) ^ flip;
  endfunction

  function automatic int next_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
    end
    burst_left--;
    return 0;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hffff;
          2: return 16'h8000;
          default: return 16'h7fff;
        endcase
      end
      1, 2: return 16'h8000 + 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_sample(input logic [15:0] raw, input logic typed,
                             input logic [15:0] want);
    int          gap;
    logic [15:0] predicted;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= raw;
    do @(posedge clk); while (!in_ready);
    predicted = biquad_output(raw);
    awaited_out.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (awaited_out.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SIGN_MODE:   mode_signed  = val[0];
      REG_COEF_FEED_0: feed_coef[0] = val[15:0];
      REG_COEF_FEED_1: feed_coef[1] = val[15:0];
      REG_COEF_FEED_2: feed_coef[2] = val[15:0];
      REG_COEF_BACK_1: back_coef[0] = val[15:0];
      REG_COEF_BACK_2: back_coef[1] = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_phase(input coef_style_t style, input bit signed_mode);
    logic signed [15:0] c [5];
    reg_idx_t           coef_regs [5];
    int                 b2;
    int                 b1_span;
    coef_regs = '{REG_COEF_FEED_0, REG_COEF_FEED_1, REG_COEF_FEED_2,
                  REG_COEF_BACK_1, REG_COEF_BACK_2};
    case (style)
      STYLE_MAX:  foreach (c[i]) c[i] = 16'sh7fff;
      STYLE_MIN:  foreach (c[i]) c[i] = 16'sh8000;
      STYLE_WILD: foreach (c[i]) c[i] = 16'($urandom());
      default: begin
        foreach (c[i]) c[i] = 16'(int'($urandom_range(0, 24000)) - 12000);
        // Keep the poles inside the unit circle so the history stays bounded.
        b2      = int'($urandom_range(0, 12000)) - 6000;
        b1_span = 8192 + b2 - 1000;
        c[4]    = 16'(b2);
        c[3]    = 16'(int'($urandom_range(0, 2 * b1_span)) - b1_span);
      end
    endcase
    write_reg(REG_SIGN_MODE, {31'($urandom()), signed_mode});
    foreach (coef_regs[k]) write_reg(coef_regs[k], {16'($urandom()), c[k]});
  endtask

  initial begin : receiver
    int seg_len;
    int stall_pct;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        seg_len = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        repeat (seg_len) begin
          out_ready <= ($urandom_range(0, 99) >= stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : check_out
    logic [15:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_out.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, out_sample_out);
      end else begin
        want = awaited_out.pop_front();
        if (out_sample_out !== want) begin
          errors++;
          $display("%0t: sample_out mismatch, expected %h, actual %h",
                   $time, want, out_sample_out);
        end
      end
    end
  end

  initial begin : stimulus
    coef_style_t style;
    bit          sm;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        write_reg(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        send_sample(DIRECTED[r].data[15:0], DIRECTED[r].typed, DIRECTED[r].want);
      end
    end
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: style = STYLE_MAX;
        1: style = STYLE_MIN;
        2: style = STYLE_WILD;
        default: style = ($urandom_range(0, 9) < 7) ? STYLE_STABLE : STYLE_WILD;
      endcase
      sm = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
      program_phase(style, sm);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 4 && n == 20) begin
          hold_req = 1'b1;
        end
        send_sample(pick_sample(), 1'b0, 16'h0000);
      end
    end
    in_valid <= 1'b0;
    while (awaited_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
